// ----- rtl/core/urxfc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package urxfc_pkg;

    typedef enum logic [1:0] {
        OP_RX_CHAR   = 2'd0,
        OP_HOST_READ = 2'd1,
        OP_STATUS    = 2'd2,
        OP_CTRL_SENT = 2'd3
    } t_op;

    localparam logic [1:0] REQ_NONE = 2'd0;
    localparam logic [1:0] REQ_XON  = 2'd1;
    localparam logic [1:0] REQ_XOFF = 2'd2;

    localparam logic [7:0] CH_XON  = 8'h11;
    localparam logic [7:0] CH_XOFF = 8'h13;

    localparam logic [4:0] ERR_OVERFLOW = 5'h10;

    localparam logic [2:0] CFG_HONOR_PEER   = 3'd0;
    localparam logic [2:0] CFG_XON_ANY      = 3'd1;
    localparam logic [2:0] CFG_RTS_FLOW     = 3'd2;
    localparam logic [2:0] CFG_SEND_XONXOFF = 3'd3;
    localparam logic [2:0] CFG_STOP_MARGIN  = 3'd4;
    localparam logic [2:0] CFG_RESUME_MARGIN = 3'd5;

    localparam logic [4:0] RST_STOP_MARGIN   = 5'd16;
    localparam logic [7:0] RST_RESUME_MARGIN = 8'd64;

    typedef struct packed {
        logic       read_valid;
        logic [7:0] read_byte;
        logic       rts_asserted;
        logic [1:0] pending_control;
        logic       peer_paused;
        logic [4:0] error_flags;
        logic [7:0] fill_count;
    } t_result;

endpackage

`default_nettype wire

// ----- rtl/core/uart_rx_buffer_flow_control.sv -----
// UART receive buffer with RTS and XON/XOFF flow control.
// The input channel carries one request at a time: a received character, a host
// read, a status read that returns and clears the error history, or notice that
// a pending control character has been sent. Every request yields exactly one
// result on the output channel, with the line and flow state after the request.
// Configuration is written through the plain write port while the block is idle.
// A result passes through a working register and then an output register once
// its request is accepted; a host read that pops a byte first waits in S_READ
// while the byte comes from the buffer memory, whose read data is registered.
// A new request is taken every cycle, except that a popping host read holds
// the input while the memory is read, and a stalled receiver holds the input
// only once both the working register and the output register are full.
// Reset clears the indices, fill count, flow flags and error bits, and restores
// the configuration defaults. The buffer contents are not cleared; a byte is
// only ever read back after it has been written. The buffer holds at most
// BUF_DEPTH-1 bytes.
`timescale 1ns / 1ps
`default_nettype none

module uart_rx_buffer_flow_control
    import urxfc_pkg::*;
#(
    parameter int BUF_DEPTH = 256
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [2:0] i_cfg_idx,
    input  wire logic [7:0] i_cfg_data,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [1:0] i_op,
    input  wire logic [7:0] i_rx_char,
    input  wire logic [3:0] i_rx_error_bits,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic            o_read_valid,
    output logic [7:0]      o_read_byte,
    output logic            o_rts_asserted,
    output logic [1:0]      o_pending_control,
    output logic            o_peer_paused,
    output logic [4:0]      o_error_flags,
    output logic [7:0]      o_fill_count
);

    localparam int W  = $clog2(BUF_DEPTH);
    localparam int CW = (W > 8) ? W : 8;

    typedef logic [W-1:0] t_idx;

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

    logic [7:0] mem [BUF_DEPTH];
    logic [7:0] r_mem_q;

    t_state     r_state;
    t_idx       r_wr_idx, n_wr_idx;
    t_idx       r_rd_idx, n_rd_idx;
    t_idx       r_fill, n_fill;
    logic       r_peer, n_peer;
    logic       r_rts_drop, n_rts_drop;
    logic       r_xoff_sent, n_xoff_sent;
    logic [1:0] r_req, n_req;
    logic [4:0] r_cur_err, n_cur_err;
    logic [4:0] r_hist, n_hist;

    logic       r_honor, r_xon_any, r_rts_en, r_sx_en;
    logic [7:0] r_stop, r_resume;

    t_result    r_res, n_res;
    logic       r_res_valid;
    t_result    r_out;
    logic       r_out_valid;

    logic       res_move;
    logic       in_acc;
    logic       mem_we;
    logic       mem_re;
    logic [4:0] flags;
    logic [4:0] errs;
    logic [CW-1:0] free_wr;
    logic [CW-1:0] free_rd;
    logic [CW-1:0] fill_ext;
    t_op        op;

    assign op       = t_op'(i_op);
    assign errs     = {1'b0, i_rx_error_bits};
    assign res_move = r_res_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = !((r_state == S_IDLE) && (!r_res_valid || res_move));
    assign in_acc   = i_in_valid && !o_in_stall;

    assign free_wr  = CW'(BUF_DEPTH - 2) - CW'(r_fill);
    assign free_rd  = CW'(BUF_DEPTH) - CW'(r_fill);

    always_comb begin
        n_wr_idx    = r_wr_idx;
        n_rd_idx    = r_rd_idx;
        n_fill      = r_fill;
        n_peer      = r_peer;
        n_rts_drop  = r_rts_drop;
        n_xoff_sent = r_xoff_sent;
        n_req       = r_req;
        n_cur_err   = r_cur_err;
        n_hist      = r_hist;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        flags       = r_cur_err;
        unique case (op)
            OP_RX_CHAR: begin
                if (errs != 5'd0) begin
                    n_cur_err = r_cur_err | errs;
                    n_hist    = r_hist | errs;
                end else if (r_honor && (i_rx_char == CH_XOFF)) begin
                    n_peer = 1'b1;
                end else if (r_honor && ((i_rx_char == CH_XON) || (r_peer && r_xon_any))) begin
                    n_peer = 1'b0;
                end else if (r_fill == t_idx'(BUF_DEPTH - 1)) begin
                    n_cur_err = r_cur_err | ERR_OVERFLOW;
                    n_hist    = r_hist | ERR_OVERFLOW;
                end else begin
                    mem_we   = in_acc;
                    n_wr_idx = (r_wr_idx == t_idx'(BUF_DEPTH - 1)) ? '0 : r_wr_idx + t_idx'(1);
                    n_fill   = r_fill + t_idx'(1);
                    if ((r_rts_en || r_sx_en) && (free_wr < CW'(r_stop))) begin
                        if (r_rts_en) begin
                            n_rts_drop = 1'b1;
                        end
                        if (r_sx_en && !r_xoff_sent) begin
                            n_xoff_sent = 1'b1;
                            n_req       = REQ_XOFF;
                        end
                    end
                end
                flags = n_cur_err;
            end
            OP_HOST_READ: begin
                if (r_fill != '0) begin
                    mem_re   = in_acc;
                    n_rd_idx = (r_rd_idx == t_idx'(BUF_DEPTH - 1)) ? '0 : r_rd_idx + t_idx'(1);
                    n_fill   = r_fill - t_idx'(1);
                    if ((r_rts_drop || r_xoff_sent) && (free_rd > CW'(r_resume))) begin
                        n_rts_drop = 1'b0;
                        if (r_xoff_sent) begin
                            n_req       = REQ_XON;
                            n_xoff_sent = 1'b0;
                        end
                    end
                end
            end
            OP_STATUS: begin
                flags     = r_hist;
                n_hist    = 5'd0;
                n_cur_err = 5'd0;
            end
            OP_CTRL_SENT: begin
                n_req = REQ_NONE;
            end
            default: begin
                n_req = r_req;
            end
        endcase
    end

    assign fill_ext = CW'(n_fill);

    always_comb begin
        n_res.read_valid      = (op == OP_HOST_READ) && (r_fill != '0);
        n_res.read_byte       = 8'd0;
        n_res.rts_asserted    = !n_rts_drop;
        n_res.pending_control = n_req;
        n_res.peer_paused     = n_peer;
        n_res.error_flags     = flags;
        n_res.fill_count      = (fill_ext > CW'(255)) ? 8'hFF : fill_ext[7:0];
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_wr_idx] <= i_rx_char;
        end
        if (mem_re) begin
            r_mem_q <= mem[r_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wr_idx    <= '0;
            r_rd_idx    <= '0;
            r_fill      <= '0;
            r_peer      <= 1'b0;
            r_rts_drop  <= 1'b0;
            r_xoff_sent <= 1'b0;
            r_req       <= REQ_NONE;
            r_cur_err   <= 5'd0;
            r_hist      <= 5'd0;
            r_honor     <= 1'b0;
            r_xon_any   <= 1'b0;
            r_rts_en    <= 1'b0;
            r_sx_en     <= 1'b0;
            r_stop      <= 8'(RST_STOP_MARGIN);
            r_resume    <= RST_RESUME_MARGIN;
            r_res_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_HONOR_PEER:    r_honor  <= i_cfg_data[0];
                    CFG_XON_ANY:       r_xon_any <= i_cfg_data[0];
                    CFG_RTS_FLOW:      r_rts_en <= i_cfg_data[0];
                    CFG_SEND_XONXOFF:  r_sx_en  <= i_cfg_data[0];
                    CFG_STOP_MARGIN:   r_stop   <= i_cfg_data;
                    CFG_RESUME_MARGIN: r_resume <= i_cfg_data;
                    default:           r_stop   <= r_stop;
                endcase
            end

            if (res_move) begin
                r_out       <= r_res;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    r_res_valid <= (in_acc && !mem_re) || (r_res_valid && !res_move);
                    if (in_acc) begin
                        r_wr_idx    <= n_wr_idx;
                        r_rd_idx    <= n_rd_idx;
                        r_fill      <= n_fill;
                        r_peer      <= n_peer;
                        r_rts_drop  <= n_rts_drop;
                        r_xoff_sent <= n_xoff_sent;
                        r_req       <= n_req;
                        r_cur_err   <= n_cur_err;
                        r_hist      <= n_hist;
                        r_res       <= n_res;
                        if (mem_re) begin
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    r_res.read_byte <= r_mem_q;
                    r_res_valid     <= 1'b1;
                    r_state         <= S_IDLE;
                end
                default: begin
                    r_res_valid <= r_res_valid && !res_move;
                    r_state     <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_read_valid      = r_out.read_valid;
    assign o_read_byte       = r_out.read_byte;
    assign o_rts_asserted    = r_out.rts_asserted;
    assign o_pending_control = r_out.pending_control;
    assign o_peer_paused     = r_out.peer_paused;
    assign o_error_flags     = r_out.error_flags;
    assign o_fill_count      = r_out.fill_count;

`ifndef SYNTH
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= t_idx'(BUF_DEPTH - 1))
        else $error("fill count beyond buffer capacity");

    a_read_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> !r_res_valid)
        else $error("result slot busy during memory read");

    a_read_enters_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (op == OP_HOST_READ) && (r_fill != '0)) |=> (r_state == S_READ))
        else $error("popping read did not wait for memory data");

    a_empty_indices: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill == '0) |-> (r_wr_idx == r_rd_idx))
        else $error("indices differ with an empty buffer");

    a_no_write_on_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_re |-> !mem_we)
        else $error("buffer written and read by one request");
`endif

endmodule

`default_nettype wire

// ----- tb/uart_rx_buffer_flow_control_test.sv -----
`timescale 1ns / 1ps

module uart_rx_buffer_flow_control_test;
    import urxfc_pkg::*;

    localparam int DEPTH       = 256;
    localparam int LONG_HOLD   = 150;
    localparam int STALL_LIMIT = 3000;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic [2:0] i_cfg_idx = '0;
    logic [7:0] i_cfg_data = '0;
    logic       i_in_valid = 1'b0;
    logic [1:0] i_op = '0;
    logic [7:0] i_rx_char = '0;
    logic [3:0] i_rx_error_bits = '0;
    logic       i_out_stall = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic       o_read_valid;
    logic [7:0] o_read_byte;
    logic       o_rts_asserted;
    logic [1:0] o_pending_control;
    logic       o_peer_paused;
    logic [4:0] o_error_flags;
    logic [7:0] o_fill_count;

    uart_rx_buffer_flow_control #(
        .BUF_DEPTH(DEPTH)
    ) u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_op             (i_op),
        .i_rx_char        (i_rx_char),
        .i_rx_error_bits  (i_rx_error_bits),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_read_valid     (o_read_valid),
        .o_read_byte      (o_read_byte),
        .o_rts_asserted   (o_rts_asserted),
        .o_pending_control(o_pending_control),
        .o_peer_paused    (o_peer_paused),
        .o_error_flags    (o_error_flags),
        .o_fill_count     (o_fill_count)
    );

    always #1 i_clk = ~i_clk;

    // Shadow of the receive buffer and its flow control state.
    logic [7:0] buf_copy [DEPTH];
    int         wr_pos = 0;
    int         rd_pos = 0;
    int         held = 0;
    logic       peer_stopped = 1'b0;
    logic       rts_down = 1'b0;
    logic       xoff_out = 1'b0;
    logic [1:0] ctl_req = REQ_NONE;
    logic [4:0] line_errors = '0;
    logic [4:0] error_log = '0;

    logic cfg_honor = 1'b0;
    logic cfg_xon_any = 1'b0;
    logic cfg_rts = 1'b0;
    logic cfg_send = 1'b0;
    int   cfg_stop = int'(RST_STOP_MARGIN);
    int   cfg_resume = int'(RST_RESUME_MARGIN);

    t_result awaited_results[$];

    logic idle_en = 1'b1;
    int   stall_left = 0;
    int   hold_left = 0;
    logic holding = 1'b0;
    int   hold_ask = 0;
    int   hold_served = 0;

    int fail_count = 0;
    int results_seen = 0;
    int n_requests = 0;
    int n_chars = 0;
    int n_reads = 0;
    int n_pops = 0;
    int n_settings = 0;

    function automatic t_result compute_rx_result(input t_op op, input logic [7:0] ch,
                                                  input logic [3:0] errs);
        t_result r;
        r = '0;
        case (op)
            OP_RX_CHAR: begin
                if (errs != 4'd0) begin
                    line_errors |= {1'b0, errs};
                    error_log |= {1'b0, errs};
                end else if (cfg_honor && ch == CH_XOFF) begin
                    peer_stopped = 1'b1;
                end else if (cfg_honor && (ch == CH_XON || (peer_stopped && cfg_xon_any))) begin
                    peer_stopped = 1'b0;
                end else if (held >= DEPTH - 1) begin
                    line_errors |= ERR_OVERFLOW;
                    error_log |= ERR_OVERFLOW;
                end else begin
                    buf_copy[wr_pos] = ch;
                    wr_pos = (wr_pos + 1) % DEPTH;
                    held++;
                    if ((cfg_rts || cfg_send) && (DEPTH - 1 - held) < cfg_stop) begin
                        if (cfg_rts) rts_down = 1'b1;
                        if (cfg_send && !xoff_out) begin
                            xoff_out = 1'b1;
                            ctl_req = REQ_XOFF;
                        end
                    end
                end
                r.error_flags = line_errors;
            end
            OP_HOST_READ: begin
                if (held != 0) begin
                    r.read_valid = 1'b1;
                    r.read_byte = buf_copy[rd_pos];
                    rd_pos = (rd_pos + 1) % DEPTH;
                    held--;
                    n_pops++;
                    if ((rts_down || xoff_out) && (DEPTH - 1 - held) > cfg_resume) begin
                        rts_down = 1'b0;
                        if (xoff_out) begin
                            ctl_req = REQ_XON;
                            xoff_out = 1'b0;
                        end
                    end
                end
                r.error_flags = line_errors;
            end
            OP_STATUS: begin
                r.error_flags = error_log;
                error_log = '0;
                line_errors = '0;
            end
            default: begin
                ctl_req = REQ_NONE;
                r.error_flags = line_errors;
            end
        endcase
        r.rts_asserted = !rts_down;
        r.pending_control = ctl_req;
        r.peer_paused = peer_stopped;
        r.fill_count = (held > 255) ? 8'd255 : 8'(held);
        return r;
    endfunction

    function automatic string result_text(input t_result r);
        return $sformatf("valid %0b byte %02h rts %0b ctl %0d paused %0b err %02h fill %0d",
                         r.read_valid, r.read_byte, r.rts_asserted, r.pending_control,
                         r.peer_paused, r.error_flags, r.fill_count);
    endfunction

    task automatic send_request(input t_op op, input logic [7:0] ch, input logic [3:0] errs);
        int gap;
        if (idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 4);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op <= op;
        i_rx_char <= ch;
        i_rx_error_bits <= errs;
        do @(posedge i_clk); while (o_in_stall);
        awaited_results.push_back(compute_rx_result(op, ch, errs));
        n_requests++;
        if (op == OP_RX_CHAR) n_chars++;
        if (op == OP_HOST_READ) n_reads++;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic put_reg(input logic [2:0] idx, input logic [7:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic configure(input logic honor, input logic xon_any, input logic rts,
                             input logic send, input logic [7:0] stop,
                             input logic [7:0] resume);
        wait_drained();
        put_reg(CFG_HONOR_PEER, {7'd0, honor});
        put_reg(CFG_XON_ANY, {7'd0, xon_any});
        put_reg(CFG_RTS_FLOW, {7'd0, rts});
        put_reg(CFG_SEND_XONXOFF, {7'd0, send});
        put_reg(CFG_STOP_MARGIN, stop);
        put_reg(CFG_RESUME_MARGIN, resume);
        i_cfg_we <= 1'b0;
        cfg_honor = honor;
        cfg_xon_any = xon_any;
        cfg_rts = rts;
        cfg_send = send;
        cfg_stop = int'(stop);
        cfg_resume = int'(resume);
        n_settings++;
    endtask

    task automatic random_traffic(input int count, input int write_pct);
        for (int k = 0; k < count; k++) begin
            t_op        op;
            logic [7:0] ch;
            logic [3:0] errs;
            int         pick;
            pick = $urandom_range(0, 99);
            if (pick >= 94) op = OP_CTRL_SENT;
            else if (pick >= 89) op = OP_STATUS;
            else if (pick < write_pct) op = OP_RX_CHAR;
            else op = OP_HOST_READ;
            case ($urandom_range(0, 9))
                0: ch = CH_XON;
                1: ch = CH_XOFF;
                default: ch = 8'($urandom_range(0, 255));
            endcase
            errs = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(1, 15)) : 4'd0;
            send_request(op, ch, errs);
        end
    endtask

    task automatic test_errors_and_status();
        send_request(OP_RX_CHAR, 8'h00, 4'h0);
        send_request(OP_RX_CHAR, 8'hFF, 4'h0);
        send_request(OP_RX_CHAR, 8'h5A, 4'h1);
        send_request(OP_RX_CHAR, 8'h5A, 4'h2);
        send_request(OP_STATUS, 8'h00, 4'h0);
        send_request(OP_RX_CHAR, 8'h5A, 4'h4);
        send_request(OP_RX_CHAR, 8'hA5, 4'h8);
        send_request(OP_RX_CHAR, 8'hA5, 4'hF);
        send_request(OP_STATUS, 8'h00, 4'h0);
        send_request(OP_STATUS, 8'h00, 4'h0);
        send_request(OP_HOST_READ, 8'h00, 4'h0);
        send_request(OP_HOST_READ, 8'h00, 4'h0);
        send_request(OP_HOST_READ, 8'h00, 4'h0);
        send_request(OP_CTRL_SENT, 8'h00, 4'h0);
    endtask

    task automatic test_peer_flow();
        configure(1'b1, 1'b0, 1'b0, 1'b1, 8'd16, 8'd64);
        send_request(OP_RX_CHAR, CH_XOFF, 4'h0);
        send_request(OP_RX_CHAR, 8'h41, 4'h0);
        send_request(OP_RX_CHAR, CH_XON, 4'h0);
        send_request(OP_RX_CHAR, CH_XON, 4'h0);
        send_request(OP_RX_CHAR, CH_XOFF, 4'h2);
        configure(1'b1, 1'b1, 1'b0, 1'b1, 8'd16, 8'd64);
        send_request(OP_RX_CHAR, CH_XOFF, 4'h0);
        send_request(OP_RX_CHAR, 8'h7E, 4'h0);
        configure(1'b0, 1'b1, 1'b0, 1'b0, 8'd16, 8'd64);
        send_request(OP_RX_CHAR, CH_XOFF, 4'h0);
        send_request(OP_RX_CHAR, CH_XON, 4'h0);
        repeat (4) send_request(OP_HOST_READ, 8'h00, 4'h0);
        send_request(OP_STATUS, 8'h00, 4'h0);
    endtask

    task automatic test_fill_and_drain();
        configure(1'b0, 1'b0, 1'b1, 1'b1, 8'd16, 8'd64);
        repeat (DEPTH) send_request(OP_RX_CHAR, 8'($urandom_range(0, 255)), 4'h0);
        send_request(OP_CTRL_SENT, 8'h00, 4'h0);
        repeat (DEPTH) send_request(OP_HOST_READ, 8'($urandom_range(0, 255)), 4'h0);
        send_request(OP_STATUS, 8'h00, 4'h0);
        send_request(OP_CTRL_SENT, 8'h00, 4'h0);
    endtask

    task automatic test_backpressure();
        hold_ask++;
        repeat (40) begin
            send_request($urandom_range(0, 1) ? OP_RX_CHAR : OP_HOST_READ,
                         8'($urandom_range(0, 255)), 4'h0);
        end
        i_in_valid <= 1'b0;
        while (hold_served != hold_ask) @(posedge i_clk);
    endtask

    task automatic test_random_phases();
        configure(1'b1, 1'b0, 1'b1, 1'b1, 8'd200, 8'd230);
        random_traffic(200, 70);
        configure(1'b0, 1'b0, 1'b1, 1'b0, 8'd255, 8'd0);
        random_traffic(200, 60);
        configure(1'b1, 1'b1, 1'b0, 1'b1, 8'd0, 8'd255);
        random_traffic(200, 55);
        repeat (3) begin
            configure(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            random_traffic(200, $urandom_range(40, 80));
        end
        idle_en <= 1'b0;
        configure(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b1, 1'b1,
                  8'($urandom_range(150, 255)), 8'($urandom_range(150, 255)));
        random_traffic(200, 65);
    endtask

    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        logic    stall_next;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = {o_read_valid, o_read_byte, o_rts_asserted, o_pending_control,
                   o_peer_paused, o_error_flags, o_fill_count};
            if (awaited_results.size() == 0) begin
                fail_count++;
                if (fail_count <= 10) $display("unexpected result: %s", result_text(got));
            end else begin
                want = awaited_results.pop_front();
                if (got !== want) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("mismatch on result %0d", results_seen);
                        $display("  expected %s", result_text(want));
                        $display("  actual   %s", result_text(got));
                    end
                end
                results_seen++;
            end
        end
        stall_next = 1'b0;
        if (holding) begin
            if (hold_left == 0) begin
                holding = 1'b0;
                hold_served++;
            end else begin
                hold_left--;
                stall_next = 1'b1;
            end
        end else if (hold_served != hold_ask) begin
            holding = 1'b1;
            hold_left = LONG_HOLD;
            stall_next = 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            stall_next = 1'b1;
        end else if (idle_en && $urandom_range(0, 3) == 0) begin
            stall_left = $urandom_range(0, 3);
            stall_next = 1'b1;
        end
        i_out_stall <= stall_next;
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) quiet = 0;
            else quiet++;
        end
        $display("timeout: nothing accepted for %0d cycles", STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_errors_and_status();
        test_peer_flow();
        test_fill_and_drain();
        test_backpressure();
        test_random_phases();
        wait_drained();
        repeat (10) @(posedge i_clk);
        $display("Run covered %0d requests: %0d received characters, %0d host reads, %0d pops.",
                 n_requests, n_chars, n_reads, n_pops);
        $display("Results checked: %0d across %0d register settings; failures: %0d.",
                 results_seen, n_settings, fail_count);
        if (fail_count == 0 && awaited_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
